@@ src/sil_pkg.sv @@
// shared types, codes and defaults for the sorted insertion list
package sil_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 6;
  localparam int STATUS_W      = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_READOUT = 1'b1;

  typedef struct packed {
    logic                       last;
    logic [STATUS_W-1:0]        status;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;
  } sil_res_t;

endpackage

@@ src/sil_mem.sv @@
// value store: one write port, one read port with registered read data
module sil_mem #(
  parameter int DEPTH = sil_pkg::DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [sil_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]                     raddr,
  output logic signed [sil_pkg::VALUE_W-1:0] rdata
);

  logic signed [sil_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/sil_ctrl.sv @@
// sequencer with the single signed comparator: insert shift and ordered read-out
module sil_ctrl #(
  parameter int DEPTH = sil_pkg::DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic signed [sil_pkg::VALUE_W-1:0] in_value,
  output logic                               res_valid,
  input  logic                               res_ready,
  output sil_pkg::sil_res_t                  res,
  output logic                               we,
  output logic [AW-1:0]                      waddr,
  output logic signed [sil_pkg::VALUE_W-1:0] wdata,
  output logic [AW-1:0]                      raddr,
  input  logic signed [sil_pkg::VALUE_W-1:0] rdata
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INS_RD   = 3'd1;
  localparam logic [2:0] ST_INS_CMP  = 3'd2;
  localparam logic [2:0] ST_INS_PUT  = 3'd3;
  localparam logic [2:0] ST_OUT_RD   = 3'd4;
  localparam logic [2:0] ST_OUT_EMIT = 3'd5;
  localparam logic [2:0] ST_STATUS   = 3'd6;

  logic [2:0]                         state, state_next;
  logic [CW-1:0]                      count, count_next;
  logic [AW-1:0]                      idx, idx_next;
  logic signed [sil_pkg::VALUE_W-1:0] value, value_next;
  logic [sil_pkg::STATUS_W-1:0]       stat, stat_next;
  logic                               ge;
  logic                               out_last;

  // the one comparator
  assign ge = (rdata >= value);

  assign in_ready  = (state == ST_IDLE);
  assign raddr     = idx;
  assign out_last  = ((CW'(idx) + CW'(1)) == count);
  assign res_valid = (state == ST_STATUS) || (state == ST_OUT_EMIT);

  always_comb begin
    res.value    = '0;
    res.position = '0;
    res.status   = stat;
    res.last     = 1'b1;
    if (state == ST_OUT_EMIT) begin
      res.value    = rdata;
      res.position = sil_pkg::POS_W'(idx);
      res.status   = sil_pkg::STATUS_OK;
      res.last     = out_last;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    value_next = value;
    stat_next  = stat;
    we         = 1'b0;
    waddr      = idx + AW'(1);
    wdata      = rdata;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          value_next = in_value;
          if (in_mode == sil_pkg::MODE_INSERT) begin
            if (count == CW'(DEPTH)) begin
              stat_next  = sil_pkg::STATUS_FULL;
              state_next = ST_STATUS;
            end else if (count == '0) begin
              we         = 1'b1;
              waddr      = '0;
              wdata      = in_value;
              count_next = count + CW'(1);
              stat_next  = sil_pkg::STATUS_OK;
              state_next = ST_STATUS;
            end else begin
              idx_next   = AW'(count - CW'(1));
              state_next = ST_INS_RD;
            end
          end else begin
            if (count == '0) begin
              stat_next  = sil_pkg::STATUS_EMPTY;
              state_next = ST_STATUS;
            end else begin
              idx_next   = '0;
              state_next = ST_OUT_RD;
            end
          end
        end
      end
      ST_INS_RD: begin
        state_next = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        we = 1'b1;
        if (ge) begin
          wdata = rdata;
          if (idx == '0) begin
            state_next = ST_INS_PUT;
          end else begin
            idx_next   = idx - AW'(1);
            state_next = ST_INS_RD;
          end
        end else begin
          wdata      = value;
          count_next = count + CW'(1);
          stat_next  = sil_pkg::STATUS_OK;
          state_next = ST_STATUS;
        end
      end
      ST_INS_PUT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = value;
        count_next = count + CW'(1);
        stat_next  = sil_pkg::STATUS_OK;
        state_next = ST_STATUS;
      end
      ST_OUT_RD: begin
        state_next = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        if (res_ready) begin
          if (out_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = ST_OUT_RD;
          end
        end
      end
      ST_STATUS: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    value <= value_next;
    stat  <= stat_next;
  end

  a_ready_excludes_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !res_valid)
    else $error("input ready while a result is pending");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_count_moves_with_write: assert property (@(posedge clk) disable iff (rst)
    (count != count_next) |-> we && (count_next == count + CW'(1)))
    else $error("count changed without a store write");

  a_write_only_on_insert: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_INS_CMP) || (state == ST_INS_PUT)
           || (state == ST_IDLE && in_valid && in_mode == sil_pkg::MODE_INSERT))
    else $error("store written outside an insert");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_CMP) |-> (count < CW'(DEPTH)) && (CW'(idx) < count))
    else $error("insert shift beyond stored entries");

endmodule

@@ src/sorted_insertion_list.sv @@
// top level of the sorted insertion list with the output register
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: new_value, s_tuser: mode
//  m_*       out  m_tvalid/m_tready  m_tdata: out_value, position, status; m_tlast: last
//
// insert: stored values not below the new value move up one slot, from the top down,
// and the new value is written below them; empty store: direct write; full: status only
// read-out: values read and emitted in order from position 0; empty store: status only
// the store has one write port and one read port with registered read; one comparator
// rst is synchronous; it empties the store at once, no clearing pass
// a stalled m_tready holds the sequencer; s_tready is high only between requests
module sorted_insertion_list #(
  parameter int DEPTH = sil_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] new_value
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] out_value, [37:32] position, [39:38] status
  output logic        m_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sil_pkg::sil_res_t                  res, res_q;
  logic                               res_valid, res_ready;
  logic                               we;
  logic [AW-1:0]                      waddr, raddr;
  logic signed [sil_pkg::VALUE_W-1:0] wdata, rdata;

  sil_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_value  ($signed(s_tdata)),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  sil_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign m_tdata = {res_q.status, res_q.position, res_q.value};
  assign m_tlast = res_q.last;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the sorted insertion list with a scoreboard class
module tb;

  localparam int LIST_DEPTH = sil_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_REQUESTS = 240;
  localparam int CALM_REQUESTS = 40;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 80;

  class sil_scoreboard;
    logic signed [sil_pkg::VALUE_W-1:0] sorted_values[$];
    sil_pkg::sil_res_t pending_results[$];
    int depth;
    int errors;

    function new(int depth_i);
      depth = depth_i;
      errors = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    // work out what one accepted request produces
    function void note_request(logic mode, logic signed [sil_pkg::VALUE_W-1:0] value);
      sil_pkg::sil_res_t res;
      int slot;
      res = '0;
      res.last = 1'b1;
      if (mode == sil_pkg::MODE_INSERT) begin
        if (sorted_values.size() >= depth) begin
          res.status = sil_pkg::STATUS_FULL;
        end else begin
          slot = 0;
          while (slot < sorted_values.size() && sorted_values[slot] < value) slot++;
          sorted_values.insert(slot, value);
          res.status = sil_pkg::STATUS_OK;
        end
        pending_results.push_back(res);
      end else if (sorted_values.size() == 0) begin
        res.status = sil_pkg::STATUS_EMPTY;
        pending_results.push_back(res);
      end else begin
        foreach (sorted_values[i]) begin
          res.value = sorted_values[i];
          res.position = sil_pkg::POS_W'(i);
          res.status = sil_pkg::STATUS_OK;
          res.last = (i == sorted_values.size() - 1);
          pending_results.push_back(res);
        end
      end
    endfunction

    task check_result(logic [39:0] data, logic tlast);
      sil_pkg::sil_res_t got, want;
      got = {tlast, data};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value)
          report_mismatch($sformatf("value %0d, wanted %0d", got.value, want.value));
        if (got.position !== want.position)
          report_mismatch($sformatf("position %0d, wanted %0d", got.position,
                                    want.position));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, wanted %b", got.last, want.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  bit calm = 1'b0;
  bit hold_armed = 1'b0;
  sil_scoreboard sb = new(LIST_DEPTH);

  sorted_insertion_list #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  task automatic send_request(input logic mode, input logic [31:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(mode, value);
    if (!calm && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // result side
  initial begin
    int span;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if (hold_armed) begin
        hold_armed = 1'b0;
        m_tready <= 1'b0;
        span = 0;
        while (span < LONG_HOLD) begin
          @(posedge clk);
          span++;
        end
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= sil_pkg::MODE_INSERT;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty store, extremes, duplicates, fill up, full store
    send_request(sil_pkg::MODE_READOUT, 32'h0);
    send_request(sil_pkg::MODE_INSERT, 32'h0);
    send_request(sil_pkg::MODE_READOUT, 32'h0);
    send_request(sil_pkg::MODE_INSERT, 32'h8000_0000);
    send_request(sil_pkg::MODE_INSERT, 32'h7fff_ffff);
    send_request(sil_pkg::MODE_INSERT, 32'hffff_ffff);
    send_request(sil_pkg::MODE_INSERT, 32'h0000_0001);
    send_request(sil_pkg::MODE_INSERT, 32'h0);
    send_request(sil_pkg::MODE_INSERT, 32'h7fff_ffff);
    send_request(sil_pkg::MODE_INSERT, 32'h8000_0000);
    send_request(sil_pkg::MODE_READOUT, 32'hffff_ffff);
    send_request(sil_pkg::MODE_INSERT, 32'h5555_5555);
    send_request(sil_pkg::MODE_INSERT, 32'haaaa_aaaa);
    send_request(sil_pkg::MODE_READOUT, 32'h0);
    send_request(sil_pkg::MODE_INSERT, 32'd7);
    send_request(sil_pkg::MODE_INSERT, -32'sd7);
    send_request(sil_pkg::MODE_INSERT, 32'd100);
    send_request(sil_pkg::MODE_INSERT, -32'sd100);
    send_request(sil_pkg::MODE_INSERT, 32'd2);
    send_request(sil_pkg::MODE_INSERT, -32'sd2);
    send_request(sil_pkg::MODE_INSERT, 32'h1234_5678);
    send_request(sil_pkg::MODE_READOUT, 32'h0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 60) hold_armed = 1'b1;
      if (i == RANDOM_REQUESTS - CALM_REQUESTS) calm = 1'b1;
      send_request($urandom_range(0, 1) ? sil_pkg::MODE_READOUT : sil_pkg::MODE_INSERT,
                   pick_value());
    end
    s_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS sorted_insertion_list");
    end else begin
      $display("FAIL sorted_insertion_list");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("FAIL sorted_insertion_list");
    $finish;
  end
endmodule
